// ===== hw/rtl/mh2_pkg.sv =====
// shared constants and command/status types for the murmur2 string hash
package mh2_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned NbytesW = 3;
  localparam int unsigned InDataW = 72;

  localparam logic [HashW-1:0] MixM     = 32'h5bd1e995;
  localparam int unsigned      MixR     = 24;
  localparam int unsigned      FinR1    = 13;
  localparam int unsigned      FinR2    = 15;
  localparam logic [HashW-1:0] SeedInit = 32'd95032;

  typedef struct packed {
    logic load;
    logic mix;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic last;
  } sts_t;

endpackage

// ===== hw/rtl/murmur2_string_hash_top.sv =====
// top level of the murmur2 string hash
//
//  channel  dir  signals                                        content
//  s_axis   in   tvalid tready tdata[71:0] tuser tlast          one word beat
//  m_axis   out  tvalid tready tdata[31:0]                      finished hash
//  cfg      in   cfg_wr_en cfg_wr_data[31:0]                    hash seed
//
//  a full word beat goes through load (multiply), then mix into the hash
//  a tail beat is folded in by the load multiplier; an empty beat only loads the hash
//  a last beat adds a finalize step that writes the output register
//  finalize waits while an earlier result still sits untaken on m_axis
//  reset sets the seed to 95032 and the running hash to zero
module murmur2_string_hash_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [mh2_pkg::HashW-1:0]    cfg_wr_data,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // data_word[31:0], bytes_valid[34:32], total_length[66:35], zero[71:67]
  input  logic [mh2_pkg::InDataW-1:0]  s_axis_tdata,
  // first_item
  input  logic                         s_axis_tuser,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // hash_value[31:0]
  output logic [mh2_pkg::HashW-1:0]    m_axis_tdata
);

  mh2_pkg::cmd_t cmd;
  mh2_pkg::sts_t sts;

  mh2_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mh2_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_axis_tdata),
    .in_first    (s_axis_tuser),
    .in_last     (s_axis_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .hash_out    (m_axis_tdata)
  );

endmodule

// ===== hw/rtl/mh2_ctrl.sv =====
// controller state machine for the murmur2 string hash
module mh2_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mh2_pkg::sts_t sts,
  output mh2_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_FIN
  } state_t;

  state_t state;
  logic   last_pend;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign cmd.load = (state == S_IDLE) && in_valid;
  assign cmd.mix  = (state == S_MIX);
  assign cmd.fin  = (state == S_FIN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_pend <= sts.last;
            if (sts.full) begin
              state <= S_MIX;
            end else if (sts.last) begin
              state <= S_FIN;
            end
          end
        end
        S_MIX: begin
          state <= last_pend ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mix, cmd.fin}))
    else $error("more than one datapath command at once");

  a_full_to_mix: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && sts.full) |=> (state == S_MIX))
    else $error("full word beat did not enter mix");

  a_mix_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_MIX) |=> (state != S_MIX))
    else $error("mix lasted more than one cycle");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result raised outside finalize");
`endif

endmodule

// ===== hw/rtl/mh2_datapath.sv =====
// seed register, running hash, key mixing and finalizer
module mh2_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [mh2_pkg::HashW-1:0]       cfg_wr_data,
  input  logic [mh2_pkg::InDataW-1:0]     in_data,
  input  logic                            in_first,
  input  logic                            in_last,
  input  mh2_pkg::cmd_t                   cmd,
  output mh2_pkg::sts_t                   sts,
  output logic [mh2_pkg::HashW-1:0]       hash_out
);

  logic [mh2_pkg::HashW-1:0]   seed;
  logic [mh2_pkg::HashW-1:0]   hash_r;
  logic [mh2_pkg::HashW-1:0]   k_r;

  logic [mh2_pkg::HashW-1:0]   word;
  logic [mh2_pkg::NbytesW-1:0] nbytes;
  logic [mh2_pkg::HashW-1:0]   total;
  logic                        tail;
  logic [mh2_pkg::HashW-1:0]   tail_mask;
  logic [mh2_pkg::HashW-1:0]   hsel;
  logic [mh2_pkg::HashW-1:0]   hash_load;
  logic [mh2_pkg::HashW-1:0]   kx;
  logic [mh2_pkg::HashW-1:0]   hash_mix;
  logic [mh2_pkg::HashW-1:0]   fx;
  logic [mh2_pkg::HashW-1:0]   fm;

  assign word   = in_data[31:0];
  assign nbytes = in_data[34:32];
  assign total  = in_data[66:35];

  assign sts.full = nbytes[2];
  assign sts.last = in_last;

  assign tail      = !nbytes[2] && (nbytes != 3'd0);
  assign tail_mask = {8'h00, {8{nbytes == 3'd3}}, {8{nbytes[1]}}, 8'hff};
  assign hsel      = in_first ? (seed ^ total) : hash_r;
  assign hash_load = tail ? ((hsel ^ (word & tail_mask)) * mh2_pkg::MixM) : hsel;

  assign kx       = k_r ^ (k_r >> mh2_pkg::MixR);
  assign hash_mix = (hash_r * mh2_pkg::MixM) ^ (kx * mh2_pkg::MixM);

  assign fx = hash_r ^ (hash_r >> mh2_pkg::FinR1);
  assign fm = fx * mh2_pkg::MixM;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed   <= mh2_pkg::SeedInit;
      hash_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        seed <= cfg_wr_data;
      end
      if (cmd.load) begin
        hash_r <= hash_load;
      end else if (cmd.mix) begin
        hash_r <= hash_mix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r <= word * mh2_pkg::MixM;
    end
    if (cmd.fin) begin
      hash_out <= fm ^ (fm >> mh2_pkg::FinR2);
    end
  end

endmodule
